@@ src/ptfr_pkg.sv @@
`default_nettype none

package ptfr_pkg;

    localparam int FRAME_COUNT = 4;
    localparam int PAGE_BYTES  = 4096;

    localparam int ADDR_W      = 32;
    localparam int OFFSET_W    = $clog2(PAGE_BYTES);
    localparam int PAGE_W      = ADDR_W - OFFSET_W;
    localparam int FRAME_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

    localparam int PHYS_W      = 14;
    localparam int FRAME_OUT_W = 2;
    localparam int EVPAGE_W    = 20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
    } t_req;

endpackage

`default_nettype wire

@@ src/ptfr_in_if.sv @@
`default_nettype none

interface ptfr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] virt_addr;

    modport source (output valid, output virt_addr, input ready);
    modport sink   (input valid, input virt_addr, output ready);
endinterface

`default_nettype wire

@@ src/ptfr_out_if.sv @@
`default_nettype none

interface ptfr_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] phys_addr;
    logic [1:0]  frame_used;
    logic        page_fault;
    logic        evicted;
    logic [19:0] evicted_page;

    modport source (output valid, output phys_addr, output frame_used,
                    output page_fault, output evicted, output evicted_page,
                    input ready);
    modport sink   (input valid, input phys_addr, input frame_used,
                    input page_fault, input evicted, input evicted_page,
                    output ready);
endinterface

`default_nettype wire

@@ src/ptfr_front.sv @@
`default_nettype none

module ptfr_front
    import ptfr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    ptfr_in_if.sink     i_req,
    output logic        o_q_valid,
    input  wire         i_q_ready,
    output t_req        o_q_req
);

    t_req               r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    logic w_push;
    logic w_pop;
    t_req w_split;

    // page number and offset of the incoming address
    assign w_split.page   = i_req.virt_addr[ADDR_W-1:OFFSET_W];
    assign w_split.offset = i_req.virt_addr[OFFSET_W-1:0];

    assign i_req.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_count != '0);
    assign w_pop       = o_q_valid && i_q_ready;
    assign o_q_req     = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= w_split;
        end
    end

endmodule

`default_nettype wire

@@ src/ptfr_back.sv @@
`default_nettype none

module ptfr_back
    import ptfr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_valid,
    output logic        o_q_ready,
    input  t_req        i_q_req,
    ptfr_out_if.source  o_rsp
);

    logic [PAGE_W-1:0]  r_frame_tag [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] r_frame_valid;
    logic [FRAME_W-1:0] r_ptr;

    logic                  r_out_valid;
    logic [PHYS_W-1:0]     r_out_pa;
    logic [FRAME_OUT_W-1:0] r_out_frame;
    logic                  r_out_fault;
    logic                  r_out_evicted;
    logic [EVPAGE_W-1:0]   r_out_evpage;

    logic               w_pop;
    logic               w_hit;
    logic [FRAME_W-1:0] w_hit_frame;
    logic [FRAME_W-1:0] w_frame;
    logic               w_evict;
    logic [63:0]        w_pa_full;
    logic [63:0]        w_frame_full;
    logic [63:0]        w_evpage_full;

    // parallel tag compare, lowest matching frame wins
    always_comb begin
        w_hit       = 1'b0;
        w_hit_frame = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
            if (r_frame_valid[i] && (r_frame_tag[i] == i_q_req.page)) begin
                w_hit       = 1'b1;
                w_hit_frame = FRAME_W'(i);
            end
        end
    end

    assign w_frame       = w_hit ? w_hit_frame : r_ptr;
    assign w_evict       = !w_hit && r_frame_valid[r_ptr];
    assign w_pa_full     = (64'(w_frame) << OFFSET_W) | 64'(i_q_req.offset);
    assign w_frame_full  = 64'(w_frame);
    assign w_evpage_full = w_evict ? 64'(r_frame_tag[r_ptr]) : 64'd0;

    assign o_q_ready = !r_out_valid || o_rsp.ready;
    assign w_pop     = i_q_valid && o_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= '0;
            r_ptr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_pop && !w_hit) begin
                r_frame_valid[r_ptr] <= 1'b1;
                r_ptr <= (r_ptr == FRAME_W'(FRAME_COUNT - 1)) ? '0 : r_ptr + 1'b1;
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && !w_hit) begin
            r_frame_tag[r_ptr] <= i_q_req.page;
        end
        if (w_pop) begin
            r_out_pa      <= w_pa_full[PHYS_W-1:0];
            r_out_frame   <= w_frame_full[FRAME_OUT_W-1:0];
            r_out_fault   <= !w_hit;
            r_out_evicted <= w_evict;
            r_out_evpage  <= w_evpage_full[EVPAGE_W-1:0];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.phys_addr    = r_out_pa;
    assign o_rsp.frame_used   = r_out_frame;
    assign o_rsp.page_fault   = r_out_fault;
    assign o_rsp.evicted      = r_out_evicted;
    assign o_rsp.evicted_page = r_out_evpage;

`ifndef SYNTHESIS
    a_evict_implies_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_evicted || r_out_fault))
        else $error("eviction reported without a page fault");

    a_fill_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_hit) |=> r_frame_valid[$past(r_ptr)])
        else $error("loaded frame not marked valid");

    a_evict_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_evict) |-> (&r_frame_valid))
        else $error("eviction while a free frame remains");

    a_hit_keeps_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_hit) |=> $stable(r_ptr))
        else $error("victim pointer moved on a hit");
`endif

endmodule

`default_nettype wire

@@ src/page_translate_fifo_replace_unit.sv @@
`default_nettype none

// page translation with fifo frame replacement
// i_req carries one 32-bit virtual address per transaction (valid/ready).
// o_rsp carries one result per request: physical address, frame used,
// page fault, eviction flag and the evicted page number.
// the front stage splits the address into page and offset and stores it
// in a two-entry queue; the back stage compares the page against all
// frame tags in parallel and, on a miss, loads the frame under the
// round-robin victim pointer.
// a request is registered in the queue and then in the output register
// before its result is valid on o_rsp.
// throughput: one transaction per cycle while o_rsp does not stall, set
// by the tag compare and state update in the back stage.
// reset clears all frame valid bits and the victim pointer; no clearing
// pass is needed.
// when o_rsp stalls the result holds in the output register, the queue
// keeps up to two requests, and i_req.ready drops once the queue is full.
module page_translate_fifo_replace_unit
    import ptfr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    ptfr_in_if.sink     i_req,
    ptfr_out_if.source  o_rsp
);

    logic w_q_valid;
    logic w_q_ready;
    t_req w_q_req;

    ptfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_req   (w_q_req)
    );

    ptfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_req   (w_q_req),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ptfr_pkg::*;

    typedef struct packed {
        logic [PHYS_W-1:0]      phys;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   fault;
        logic                   evict;
        logic [EVPAGE_W-1:0]    ev_page;
    } t_xlate;

    typedef struct packed {
        logic [ADDR_W-1:0] vaddr;
        logic              known;
        t_xlate            res;
    } t_dir_row;

    localparam int DIR_ROWS = 20;

    // first rows have their results worked out by hand from a clean reset
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{32'h0000_0000, 1'b1, '{14'h0000, 2'd0, 1'b1, 1'b0, 20'h00000}},
        '{32'hFFFF_FFFF, 1'b1, '{14'h1FFF, 2'd1, 1'b1, 1'b0, 20'h00000}},
        '{32'h0000_0FFF, 1'b1, '{14'h0FFF, 2'd0, 1'b0, 1'b0, 20'h00000}},
        '{32'h1234_5678, 1'b1, '{14'h2678, 2'd2, 1'b1, 1'b0, 20'h00000}},
        '{32'hABCD_E001, 1'b1, '{14'h3001, 2'd3, 1'b1, 1'b0, 20'h00000}},
        '{32'hFFFF_F000, 1'b1, '{14'h1000, 2'd1, 1'b0, 1'b0, 20'h00000}},
        '{32'h0000_1000, 1'b1, '{14'h0000, 2'd0, 1'b1, 1'b1, 20'h00000}},
        '{32'h8000_0000, 1'b1, '{14'h1000, 2'd1, 1'b1, 1'b1, 20'hFFFFF}},
        '{32'h1234_5ABC, 1'b1, '{14'h2ABC, 2'd2, 1'b0, 1'b0, 20'h00000}},
        '{32'h7FFF_FFFF, 1'b1, '{14'h2FFF, 2'd2, 1'b1, 1'b1, 20'h12345}},
        '{32'h0000_1800, 1'b1, '{14'h0800, 2'd0, 1'b0, 1'b0, 20'h00000}},
        '{32'hABCD_EFFF, 1'b1, '{14'h3FFF, 2'd3, 1'b0, 1'b0, 20'h00000}},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h0000_0001, 1'b0, '0},
        '{32'h8000_0FFF, 1'b0, '0},
        '{32'h5555_5000, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0},
        '{32'h7FFF_F123, 1'b0, '0}
    };

    localparam int PHASE_ITEMS = 510;
    localparam int LONG_STALL  = 60;

    logic i_clk;
    logic i_rst_n;

    ptfr_in_if  req_if ();
    ptfr_out_if rsp_if ();

    page_translate_fifo_replace_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predicted page table
    logic [PAGE_W-1:0]  frame_tag    [FRAME_COUNT];
    logic               frame_loaded [FRAME_COUNT];
    logic [FRAME_W-1:0] victim_ptr;

    t_xlate expected_xlates [$];

    int mismatch_cnt;
    int req_idle_pct;
    int rsp_idle_pct;
    int stall_req_cnt;
    int stall_ack_cnt;
    int stall_left;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_xlate translate_predict(input logic [ADDR_W-1:0] vaddr);
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        logic [FRAME_W-1:0]  slot;
        logic                hit;
        t_xlate              r;
        page   = vaddr[ADDR_W-1:OFFSET_W];
        offset = vaddr[OFFSET_W-1:0];
        hit    = 1'b0;
        slot   = '0;
        r      = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
            if (frame_loaded[i] && frame_tag[i] == page) begin
                hit  = 1'b1;
                slot = FRAME_W'(i);
            end
        end
        if (!hit) begin
            slot    = victim_ptr;
            r.fault = 1'b1;
            if (frame_loaded[slot]) begin
                r.evict   = 1'b1;
                r.ev_page = EVPAGE_W'(frame_tag[slot]);
            end
            frame_tag[slot]    = page;
            frame_loaded[slot] = 1'b1;
            victim_ptr = (int'(slot) == FRAME_COUNT - 1) ? '0 : slot + 1'b1;
        end
        r.phys  = PHYS_W'(int'(slot) * PAGE_BYTES + int'(offset));
        r.frame = FRAME_OUT_W'(slot);
        return r;
    endfunction

    // offer one address, wait for the transaction, then queue its result
    task automatic send_addr(input logic [ADDR_W-1:0] vaddr, input logic known,
                             input t_xlate typed_res);
        t_xlate pred;
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.virt_addr <= vaddr;
        do @(posedge i_clk); while (!req_if.ready);
        pred = translate_predict(vaddr);
        expected_xlates.push_back(known ? typed_res : pred);
    endtask

    // result side: random backpressure plus an occasional long hold-off
    always @(posedge i_clk) begin
        t_xlate got;
        t_xlate exp_res;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.phys_addr, rsp_if.frame_used, rsp_if.page_fault,
                        rsp_if.evicted, rsp_if.evicted_page};
                if (expected_xlates.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t unexpected result pa=%h frame=%0d fault=%b ev=%b evp=%h",
                                 $realtime, got.phys, got.frame, got.fault, got.evict,
                                 got.ev_page);
                end else begin
                    exp_res = expected_xlates.pop_front();
                    if (got.phys !== exp_res.phys || got.frame !== exp_res.frame ||
                        got.fault !== exp_res.fault || got.evict !== exp_res.evict ||
                        got.ev_page !== exp_res.ev_page) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t mismatch exp pa=%h frame=%0d fault=%b ev=%b evp=%h",
                                     $realtime, exp_res.phys, exp_res.frame, exp_res.fault,
                                     exp_res.evict, exp_res.ev_page);
                            $display("    got pa=%h frame=%0d fault=%b ev=%b evp=%h",
                                     got.phys, got.frame, got.fault, got.evict,
                                     got.ev_page);
                        end
                    end
                end
            end
            if (stall_ack_cnt != stall_req_cnt) begin
                stall_ack_cnt = stall_req_cnt;
                stall_left    = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    initial begin
        #200000;
        $display("FAIL page_translate_fifo_replace_unit");
        $finish;
    end

    initial begin
        logic [PAGE_W-1:0]  page;
        logic [PAGE_W-1:0]  pool_base;
        int                 sel;
        int                 k;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.virt_addr = '0;
        rsp_if.ready     = 1'b0;
        mismatch_cnt     = 0;
        stall_req_cnt    = 0;
        stall_ack_cnt    = 0;
        stall_left       = 0;
        req_idle_pct     = 7;
        rsp_idle_pct     = 63;
        victim_ptr       = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            frame_tag[i]    = '0;
            frame_loaded[i] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_addr(DIR_TABLE[r].vaddr, DIR_TABLE[r].known, DIR_TABLE[r].res);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    req_idle_pct = 7;
                    rsp_idle_pct <= 63;
                end
                1: begin
                    req_idle_pct = 63;
                    rsp_idle_pct <= 7;
                end
                default: begin
                    req_idle_pct = 0;
                    rsp_idle_pct <= 0;
                    // sender keeps offering while the result side is held off
                    stall_req_cnt <= stall_req_cnt + 1;
                end
            endcase
            pool_base = PAGE_W'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    // revisit a mapped page for hits
                    k    = $urandom_range(FRAME_COUNT - 1);
                    page = frame_loaded[k] ? frame_tag[k] : PAGE_W'($urandom());
                end else if (sel < 85) begin
                    // small working set a bit larger than the frame count
                    page = pool_base ^ PAGE_W'($urandom_range(5));
                end else begin
                    page = PAGE_W'($urandom());
                end
                send_addr({page, OFFSET_W'($urandom())}, 1'b0, '0);
            end
        end
        req_if.valid <= 1'b0;

        while (expected_xlates.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("PASS page_translate_fifo_replace_unit");
        else
            $display("FAIL page_translate_fifo_replace_unit");
        $finish;
    end

endmodule

@@ files.f @@
src/ptfr_pkg.sv
src/ptfr_in_if.sv
src/ptfr_out_if.sv
src/ptfr_front.sv
src/ptfr_back.sv
src/page_translate_fifo_replace_unit.sv
bench/tb.sv
